### rtl/punf_pkg.sv
// ----------------------------------------------------------------------------
// punf_pkg
// Shared types and constants for the scanline unfilter.
// ----------------------------------------------------------------------------
package punf_pkg;

  localparam int WIDTH_W    = 14;  // width_pixels register
  localparam int HEIGHT_W   = 16;  // height_rows register
  localparam int BPP_W      = 4;   // bytes_per_pixel register
  localparam int LEN_W      = WIDTH_W + BPP_W;  // width * bpp product
  localparam int SLOT_W     = 3;   // left-neighbor slot, up to 8 bytes/pixel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_ROW_BYTES_DEF       = 8192;
  localparam int MAX_BYTES_PER_PIXEL_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BPP    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef enum logic [1:0] {
    STAT_DATA       = 2'd0,
    STAT_BAD_FILTER = 2'd1,
    STAT_ROW_CFG    = 2'd2
  } status_t;

  // One result-producing beat handed from the sequencer to the datapath.
  typedef struct packed {
    logic [7:0]        data;
    filt_t             filter;
    logic [SLOT_W-1:0] slot;
    logic              have_left;  // column past the first pixel
    logic              first_row;  // no row above
    status_t           status;
    logic              last;
  } item_t;

endpackage

### rtl/punf_ram.sv
// ----------------------------------------------------------------------------
// punf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module punf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/punf_ctrl.sv
// ----------------------------------------------------------------------------
// punf_ctrl
// Config registers and position sequencer: decodes each input beat.
// ----------------------------------------------------------------------------
module punf_ctrl #(
  parameter int MAX_ROW_BYTES       = punf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_BYTES_PER_PIXEL = punf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [punf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [punf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 accept,
  input  logic [7:0]                           in_byte,
  input  logic                                 in_frame_start,
  output logic                                 item_load,
  output punf_pkg::item_t                      item,
  output logic                                 rd_en,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]     addr
);
  import punf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic [WIDTH_W-1:0]  width_pixels;
  logic [HEIGHT_W-1:0] height_rows;
  logic [BPP_W-1:0]    bytes_per_pixel;

  logic [ADDR_W-1:0]   col, col_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;
  logic                awaiting, awaiting_next;
  filt_t               filter, filter_next;
  logic                first_row, first_row_next;
  logic                halted, halted_next;
  logic [ADDR_W-1:0]   row_len_m1, row_len_m1_next;
  logic [BPP_W-1:0]    row_bpp, row_bpp_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic                past_first, past_first_next;

  // state as seen by this beat, after an optional frame restart
  logic [ADDR_W-1:0]   cur_col;
  logic [HEIGHT_W-1:0] cur_row;
  logic                cur_awaiting, cur_first, cur_halted;

  logic [LEN_W-1:0]    len;
  logic                cfg_bad;
  logic [HEIGHT_W:0]   height_eff;
  logic                last_row;
  logic                slot_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels    <= WIDTH_W'(1);
      height_rows     <= HEIGHT_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_pixels    <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT: height_rows     <= cfg_data[HEIGHT_W-1:0];
        CFG_BPP:    bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row_count  <= '0;
      awaiting   <= 1'b1;
      filter     <= FILT_NONE;
      first_row  <= 1'b1;
      halted     <= 1'b0;
      row_len_m1 <= '0;
      row_bpp    <= BPP_W'(1);
      slot       <= '0;
      past_first <= 1'b0;
    end else begin
      col        <= col_next;
      row_count  <= row_count_next;
      awaiting   <= awaiting_next;
      filter     <= filter_next;
      first_row  <= first_row_next;
      halted     <= halted_next;
      row_len_m1 <= row_len_m1_next;
      row_bpp    <= row_bpp_next;
      slot       <= slot_next;
      past_first <= past_first_next;
    end
  end

  always_comb begin
    cur_col      = in_frame_start ? '0   : col;
    cur_row      = in_frame_start ? '0   : row_count;
    cur_awaiting = in_frame_start ? 1'b1 : awaiting;
    cur_first    = in_frame_start ? 1'b1 : first_row;
    cur_halted   = in_frame_start ? 1'b0 : halted;

    len     = LEN_W'(width_pixels) * LEN_W'(bytes_per_pixel);
    cfg_bad = (bytes_per_pixel == '0) ||
              (BPP_W'(MAX_BYTES_PER_PIXEL) < bytes_per_pixel) ||
              (len == '0) || (len > LEN_W'(MAX_ROW_BYTES));

    height_eff = (height_rows == '0) ? (HEIGHT_W+1)'(1) : {1'b0, height_rows};
    last_row   = ({1'b0, cur_row} + (HEIGHT_W+1)'(1)) >= height_eff;
    slot_wrap  = ({{(BPP_W-SLOT_W){1'b0}}, slot} == row_bpp - BPP_W'(1));
  end

  always_comb begin
    col_next        = col;
    row_count_next  = row_count;
    awaiting_next   = awaiting;
    filter_next     = filter;
    first_row_next  = first_row;
    halted_next     = halted;
    row_len_m1_next = row_len_m1;
    row_bpp_next    = row_bpp;
    slot_next       = slot;
    past_first_next = past_first;

    item_load      = 1'b0;
    rd_en          = 1'b0;
    addr           = cur_col;
    item.data      = in_byte;
    item.filter    = filter;
    item.slot      = slot;
    item.have_left = past_first;
    item.first_row = cur_first;
    item.status    = STAT_DATA;
    item.last      = 1'b0;

    if (accept) begin
      if (in_frame_start) begin
        col_next       = '0;
        row_count_next = '0;
        awaiting_next  = 1'b1;
        filter_next    = FILT_NONE;
        first_row_next = 1'b1;
        halted_next    = 1'b0;
      end
      if (!cur_halted) begin
        if (cur_awaiting) begin
          if (cfg_bad) begin
            item_load   = 1'b1;
            item.status = STAT_ROW_CFG;
            item.last   = 1'b1;
            halted_next = 1'b1;
          end else if (in_byte > 8'(FILT_PAETH)) begin
            item_load   = 1'b1;
            item.status = STAT_BAD_FILTER;
            item.last   = 1'b1;
            halted_next = 1'b1;
          end else begin
            filter_next     = filt_t'(in_byte[2:0]);
            row_len_m1_next = ADDR_W'(len - LEN_W'(1));
            row_bpp_next    = bytes_per_pixel;
            col_next        = '0;
            slot_next       = '0;
            past_first_next = 1'b0;
            awaiting_next   = 1'b0;
          end
        end else begin
          item_load = 1'b1;
          rd_en     = 1'b1;
          if (slot_wrap) begin
            slot_next       = '0;
            past_first_next = 1'b1;
          end else begin
            slot_next = slot + SLOT_W'(1);
          end
          if (cur_col == row_len_m1) begin
            col_next      = '0;
            awaiting_next = 1'b1;
            if (last_row) begin
              item.last      = 1'b1;
              row_count_next = '0;
              first_row_next = 1'b1;
              filter_next    = FILT_NONE;
            end else begin
              row_count_next = cur_row + HEIGHT_W'(1);
              first_row_next = 1'b0;
            end
          end else begin
            col_next = cur_col + ADDR_W'(1);
          end
        end
      end
    end
  end

endmodule

### rtl/punf_dp.sv
// ----------------------------------------------------------------------------
// punf_dp
// Row store, neighbor histories, predictor and output register.
// ----------------------------------------------------------------------------
module punf_dp #(
  parameter int MAX_ROW_BYTES = punf_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_load,
  input  punf_pkg::item_t                  item,
  input  logic                             rd_en,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0] addr,
  output logic                             s1_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output punf_pkg::status_t                out_status,
  output logic                             out_last
);
  import punf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int NSLOT  = 1 << SLOT_W;

  logic              s1_valid;
  item_t             s1_item;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_fire;
  logic              out_free;
  logic              wr_en;

  logic [7:0] above_raw;
  logic [7:0] left_hist   [NSLOT];
  logic [7:0] upleft_hist [NSLOT];

  logic [7:0]       a, b, c, pred, result;
  logic [8:0]       avg_sum;
  logic signed [9:0] pa, pb, pc;

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign s1_ready = !s1_valid || out_free;
  assign wr_en    = s1_fire && (s1_item.status == STAT_DATA);

  punf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (result),
    .re    (rd_en),
    .raddr (addr),
    .rdata (above_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      s1_item <= item;
      s1_addr <= addr;
    end
  end

  // neighbors; histories are only read after their slot is written this row
  always_comb begin
    a = s1_item.have_left ? left_hist[s1_item.slot] : 8'd0;
    b = s1_item.first_row ? 8'd0 : above_raw;
    c = (s1_item.have_left && !s1_item.first_row) ? upleft_hist[s1_item.slot] : 8'd0;

    avg_sum = {1'b0, a} + {1'b0, b};
    // distances of a + b - c from a, b and c
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b})
       - $signed({2'b00, c}) - $signed({2'b00, c});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;

    case (s1_item.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:    pred = 8'd0;
    endcase
    result = s1_item.data + pred;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_hist[s1_item.slot]   <= result;
      upleft_hist[s1_item.slot] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte   <= (s1_item.status == STAT_DATA) ? result : 8'd0;
      out_status <= s1_item.status;
      out_last   <= s1_item.last;
    end
  end

endmodule

### rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (None, Sub, Up, Average, Paeth), one byte a beat.
//
// Channel  Dir  Beat contents (lowest bit first)
// s_axis   in   tdata: stream_byte[7:0]; tuser: frame_start
// m_axis   out  tdata: pixel_byte[7:0]; tuser: status[1:0]; tlast: last_of_image
// cfg      in   cfg_index selects width_pixels, height_rows, bytes_per_pixel
//
// Sustained rate is one input beat per cycle while m_axis is not stalled;
// each data byte costs one row store read (issued on accept) and one write
// (when it leaves the compute stage). From accept to m_axis valid a beat
// passes the registered row store read and the output register.
// rst is synchronous; the row store needs no clearing pass since the first
// row of every image ignores it. A stalled m_axis holds the compute stage and
// the held read data; s_axis_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES       = punf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_BYTES_PER_PIXEL = punf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_we,
  input  logic [punf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [punf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // stream_byte[7:0]
  input  logic                            s_axis_tuser,   // frame_start
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // pixel_byte[7:0]
  output logic [1:0]                      m_axis_tuser,   // status[1:0]
  output logic                            m_axis_tlast    // last_of_image
);
  import punf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic              accept;
  logic              item_load;
  item_t             item;
  logic              rd_en;
  logic [ADDR_W-1:0] addr;
  logic              s1_ready;
  status_t           out_status;

  // input beat taken whenever the compute stage can move on
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tuser  = out_status;

  punf_ctrl #(
    .MAX_ROW_BYTES       (MAX_ROW_BYTES),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .in_byte        (s_axis_tdata),
    .in_frame_start (s_axis_tuser),
    .item_load      (item_load),
    .item           (item),
    .rd_en          (rd_en),
    .addr           (addr)
  );

  punf_dp #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_load  (item_load),
    .item       (item),
    .rd_en      (rd_en),
    .addr       (addr),
    .s1_ready   (s1_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

endmodule

### bench/png_scanline_unfilter_checker.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_checker
// Watches the config port and both streams of the scanline unfilter, rebuilds
// every expected output beat from the accepted input beats and compares the
// output beats against them in order. Reports a running failure count.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_checker #(
  parameter int MAX_ROW_BYTES       = punf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_BYTES_PER_PIXEL = punf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [punf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [punf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // stream_byte[7:0]
  input  logic                            s_axis_tuser,   // frame_start
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [7:0]                      m_axis_tdata,   // pixel_byte[7:0]
  input  logic [1:0]                      m_axis_tuser,   // status[1:0]
  input  logic                            m_axis_tlast,   // last_of_image
  output int                              failures,
  output int                              pending,
  output int                              results_checked,
  output int                              error_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import punf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  typedef struct packed {
    logic [7:0] pixel;
    status_t    status;
    logic       last;
  } pixel_beat_t;

  logic [WIDTH_W-1:0]  reg_width;
  logic [HEIGHT_W-1:0] reg_height;
  logic [BPP_W-1:0]    reg_bpp;

  logic [7:0]          row_above   [MAX_ROW_BYTES];
  logic [7:0]          left_byte   [MAX_BYTES_PER_PIXEL];
  logic [7:0]          upleft_byte [MAX_BYTES_PER_PIXEL];
  logic [WIDTH_W-1:0]  col;
  logic [HEIGHT_W-1:0] row_idx;
  logic                want_filter;
  filt_t               filt;
  logic                top_row;
  logic                halted;
  logic [LEN_W-1:0]    len_latched;   // row length in force for the running row
  logic [BPP_W-1:0]    bpp_latched;

  pixel_beat_t expected_pixels [$];
  pixel_beat_t oldest;
  int          fails = 0;
  int          checked = 0;
  int          err_seen = 0;

  function automatic void restart_frame();
    for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
      left_byte[i]   = 8'd0;
      upleft_byte[i] = 8'd0;
    end
    col         = '0;
    row_idx     = '0;
    want_filter = 1'b1;
    filt        = FILT_NONE;
    top_row     = 1'b1;
    halted      = 1'b0;
  endfunction

  function automatic void note_result(input logic [7:0] pixel, input status_t st,
                                      input logic last);
    pixel_beat_t r;
    r.pixel  = pixel;
    r.status = st;
    r.last   = last;
    expected_pixels.push_back(r);
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc)
      return a;
    return (db <= dc) ? b : c;
  endfunction

  // One accepted input beat: update state, queue the result it causes, if any.
  function automatic void unfilter_beat(input logic [7:0] sb, input logic fs);
    logic [LEN_W-1:0]    row_bytes;
    logic [WIDTH_W-1:0]  x;
    logic [SLOT_W-1:0]   slot;
    logic                have_left;
    logic [7:0]          a, b, c, guess, recon;
    logic [8:0]          pair_sum;
    logic [HEIGHT_W-1:0] rows;

    if (fs)
      restart_frame();
    if (halted)
      return;

    if (want_filter) begin
      row_bytes = LEN_W'(reg_width) * LEN_W'(reg_bpp);
      if (reg_bpp == 0 || reg_bpp > MAX_BYTES_PER_PIXEL || row_bytes == 0 ||
          row_bytes > MAX_ROW_BYTES) begin
        halted = 1'b1;
        note_result(8'd0, STAT_ROW_CFG, 1'b1);
        return;
      end
      if (sb > FILT_PAETH) begin
        halted = 1'b1;
        note_result(8'd0, STAT_BAD_FILTER, 1'b1);
        return;
      end
      filt        = filt_t'(sb[2:0]);
      len_latched = row_bytes;
      bpp_latched = reg_bpp;
      col         = '0;
      want_filter = 1'b0;
      return;
    end

    x         = col;
    slot      = SLOT_W'(x % bpp_latched);
    have_left = (x >= bpp_latched);
    a = have_left ? left_byte[slot] : 8'd0;
    b = top_row ? 8'd0 : row_above[x[ADDR_W-1:0]];
    c = (have_left && !top_row) ? upleft_byte[slot] : 8'd0;

    case (filt)
      FILT_SUB:   guess = a;
      FILT_UP:    guess = b;
      FILT_AVG: begin
        pair_sum = a + b;
        guess    = pair_sum[8:1];
      end
      FILT_PAETH: guess = paeth_pick(a, b, c);
      default:    guess = 8'd0;
    endcase
    recon = sb + guess;

    left_byte[slot]           = recon;
    upleft_byte[slot]         = b;
    row_above[x[ADDR_W-1:0]]  = recon;
    col                       = x + 1'b1;

    if (col < len_latched) begin
      note_result(recon, STAT_DATA, 1'b0);
      return;
    end

    // end of row; height 0 counts as a single row
    rows = (reg_height == 0) ? HEIGHT_W'(1) : reg_height;
    if (int'(row_idx) + 1 >= int'(rows)) begin
      restart_frame();
      note_result(recon, STAT_DATA, 1'b1);
      return;
    end
    row_idx     = row_idx + 1'b1;
    top_row     = 1'b0;
    want_filter = 1'b1;
    col         = '0;
    note_result(recon, STAT_DATA, 1'b0);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reg_width   = WIDTH_W'(1);
      reg_height  = HEIGHT_W'(1);
      reg_bpp     = BPP_W'(1);
      len_latched = LEN_W'(1);
      bpp_latched = BPP_W'(1);
      restart_frame();
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  reg_width  = cfg_data[WIDTH_W-1:0];
          CFG_HEIGHT: reg_height = cfg_data[HEIGHT_W-1:0];
          CFG_BPP:    reg_bpp    = cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        unfilter_beat(s_axis_tdata, s_axis_tuser);

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("output beat with nothing expected: pixel_byte %0d status %0d last_of_image %0d",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end else begin
          oldest = expected_pixels.pop_front();
          checked++;
          if (oldest.status != STAT_DATA)
            err_seen++;
          if (m_axis_tdata !== oldest.pixel) begin
            $error("pixel_byte: expected %0d, got %0d", oldest.pixel, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
            fails++;
          end
          if (m_axis_tlast !== oldest.last) begin
            $error("last_of_image: expected %0d, got %0d", oldest.last, m_axis_tlast);
            fails++;
          end
        end
      end
    end

    failures        <= fails;
    pending         <= expected_pixels.size();
    results_checked <= checked;
    error_results   <= err_seen;
  end

endmodule

### bench/tb_png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter
// Stimulus and verdict for the PNG scanline unfilter. A short directed run
// walks every filter type, both error kinds, halting, frame restarts, height
// zero and the register extremes, the widest legal row and one longer
// two-row image. Random images follow under four flow-control regimes; a side
// checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
  timeunit 1ns;
  timeprecision 1ps;
  import punf_pkg::*;

  // Index 3 maps to no register; the block has to ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 8;        // margin past the registered output path
  localparam int DRAIN_CYCLES  = 16;
  localparam int RUN_LIMIT_NS  = 4_000_000;
  localparam int PHASE_BEATS   = 140;      // random input beats per flow regime

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'd0;   // stream_byte[7:0]
  logic                  s_axis_tuser = 1'b0;   // frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;          // pixel_byte[7:0]
  logic [1:0]            m_axis_tuser;          // status[1:0]
  logic                  m_axis_tlast;          // last_of_image

  int failures;
  int pending;
  int results_checked;
  int error_results;

  // Flow control knobs, percent of cycles spent idle / stalled.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int tx_pct_by_phase [4] = '{0, 64, 0, 22};
  int rx_pct_by_phase [4] = '{0, 0, 64, 22};

  // What the stimulus side believes is programmed, to shape whole images.
  int   cur_w = 1;
  int   cur_h = 1;
  int   cur_bpp = 1;
  logic need_fs = 1'b1;    // next beat must open a new frame

  int beats_sent = 0;
  int settings_used = 0;

  filt_t      filter_walk [5] = '{FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH, FILT_NONE};
  logic [7:0] corner_vals [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};

  always #5 clk = ~clk;

  png_scanline_unfilter u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  png_scanline_unfilter_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked),
    .error_results   (error_results)
  );

  // Receiver: tready redrawn every cycle, so stalls land on any pipeline state.
  always @(posedge clk) begin
    m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Offer one beat, with random idle cycles ahead of it, and wait for the
  // handshake. tvalid stays high on return so back-to-back beats have no bubble.
  task automatic send_beat(input logic [7:0] sb, input logic fs);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sb;
    s_axis_tuser  <= fs;
    do
      @(posedge clk);
    while (!s_axis_tready);
    beats_sent++;
  endtask

  // Drain: no input, wait for every expected beat, then let a filter byte
  // still in flight (it gives no output) clear the pipe before touching regs.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Back-to-back register writes; we stays high across them. The unmapped
  // index goes first so its data can never leak into a real register unseen.
  task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] bpp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_BPP;
    cfg_data  <= bpp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w   = int'(w[WIDTH_W-1:0]);
    cur_h   = int'(h);
    cur_bpp = int'(bpp[BPP_W-1:0]);
    // A new geometry always starts a fresh frame, so no row ever reads
    // store entries that the previous, shorter row never wrote.
    need_fs = 1'b1;
    settings_used++;
  endtask

  // One image under the current geometry. noise_pct is the chance per row of
  // breaking it: an unknown filter type, or a row cut short by a new frame.
  task automatic send_image(input int noise_pct);
    int   len, rows, cut, r, i;
    logic broken;
    len  = cur_w * cur_bpp;
    rows = (cur_h == 0) ? 1 : cur_h;
    if ($urandom_range(3) == 0)
      need_fs = 1'b1;   // redundant frame start at an image boundary

    // bad geometry: the filter byte reports it, the rest is swallowed
    if (cur_bpp == 0 || cur_bpp > MAX_BYTES_PER_PIXEL_DEF || len == 0 ||
        len > MAX_ROW_BYTES_DEF) begin
      send_beat(8'($urandom_range(int'(FILT_PAETH))), need_fs);
      repeat ($urandom_range(2)) send_beat(8'($urandom), 1'b0);
      need_fs = 1'b1;
      return;
    end

    for (r = 0; r < rows; r++) begin
      broken = ($urandom_range(99) < noise_pct);
      if (broken && $urandom_range(1) == 0) begin
        // unknown type halts the block; trailing junk must be ignored
        send_beat(8'($urandom_range(255, int'(FILT_PAETH) + 1)), need_fs);
        repeat ($urandom_range(3)) send_beat(8'($urandom), 1'b0);
        need_fs = 1'b1;
        return;
      end
      send_beat(8'($urandom_range(int'(FILT_PAETH))), need_fs);
      need_fs = 1'b0;
      cut = broken ? $urandom_range(len - 1) : len;
      for (i = 0; i < cut; i++)
        send_beat(8'($urandom), 1'b0);
      if (broken) begin
        need_fs = 1'b1;
        return;
      end
    end
    // complete image: the block re-arms for a new one without a frame start
  endtask

  // Mostly short valid rows (at most 48 bytes); one setting in ten is illegal:
  // zero or oversized bytes per pixel, zero width, or a row past the store.
  task automatic random_geometry();
    int w, h, b;
    b = $urandom_range(1, MAX_BYTES_PER_PIXEL_DEF);
    w = $urandom_range(1, 48 / b);
    h = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
    case ($urandom_range(19))
      0: b = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, MAX_BYTES_PER_PIXEL_DEF + 1);
      1: w = ($urandom_range(1) == 0) ? 0 :
             $urandom_range(16383, MAX_ROW_BYTES_DEF / b + 1);
      default: ;
    endcase
    // unused upper bits of the narrow registers carry noise
    program_regs({2'($urandom), 14'(w)}, 16'(h), {12'($urandom), 4'(b)});
  endtask

  initial begin : stimulus
    int r, p, phase_end;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry is one pixel of one byte, one row.
    send_beat(8'(FILT_NONE), 1'b1);
    send_beat(8'hFF, 1'b0);

    // Every filter type in turn, rows of two one-byte pixels, corner values.
    settle();
    program_regs(16'd2, 16'd5, 16'd1);
    for (r = 0; r < 5; r++) begin
      send_beat(8'(filter_walk[r]), r == 0);
      send_beat(corner_vals[$urandom_range(3)], 1'b0);
      send_beat(corner_vals[$urandom_range(3)], 1'b0);
    end

    // Height zero acts as one row; the block then re-arms on its own. The
    // smallest unknown type halts it, a halted byte is dropped, and a frame
    // start carrying the largest type reports the error again.
    settle();
    program_regs(16'd1, 16'd0, 16'd1);
    send_beat(8'(FILT_UP), 1'b1);
    send_beat(8'h5A, 1'b0);
    send_beat(8'(int'(FILT_PAETH) + 1), 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    // A width of 8192 at two bytes per pixel overflows the row store.
    settle();
    program_regs(16'd8192, 16'd1, 16'd2);
    send_beat(8'(FILT_NONE), 1'b1);
    send_beat(8'h11, 1'b0);

    // Tallest image: two rows in, then abandoned by the next frame start.
    settle();
    program_regs(16'd1, 16'hFFFF, 16'd1);
    send_beat(8'(FILT_SUB), 1'b1);
    send_beat(8'h3C, 1'b0);
    send_beat(8'(FILT_AVG), 1'b0);
    send_beat(8'hC3, 1'b0);

    // Widest legal row fills the store exactly; a few bytes, then abandoned.
    settle();
    program_regs(16'd8192, 16'd1, 16'd1);
    send_beat(8'(FILT_SUB), 1'b1);
    repeat (4) send_beat(8'($urandom), 1'b0);

    // One longer image, two rows of 64 two-byte pixels read back from the store.
    settle();
    program_regs(16'd64, 16'd2, 16'd2);
    send_image(0);

    // Random images under each flow-control regime.
    for (p = 0; p < 4; p++) begin
      settle();
      tx_idle_pct  = tx_pct_by_phase[p];
      rx_stall_pct = rx_pct_by_phase[p];
      phase_end    = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        settle();
        random_geometry();
        repeat ($urandom_range(1, 3)) send_image(12);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d input beats across %0d register settings and four flow regimes.",
             beats_sent, settings_used);
    $display("Checked %0d output beats, %0d of them error reports.",
             results_checked, error_results);
    if (failures == 0 && pending == 0)
      $display("png_scanline_unfilter verification clean");
    else
      $display("png_scanline_unfilter verification failed");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("png_scanline_unfilter verification failed");
    $finish;
  end

endmodule
